### hw/rtl/battery_charge_estimator_top_macros.svh
// Assertion helpers for the estimator RTL (included by bce_queue).
// Define NO_ASSERTIONS to compile them out.
`ifndef BATTERY_CHARGE_ESTIMATOR_TOP_MACROS_SVH
`define BATTERY_CHARGE_ESTIMATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// cond implies prop in the same cycle
`define BCE_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// cond implies prop in the next cycle
`define BCE_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`else
`define BCE_ASSERT_SAME(label, clk, rst, cond, prop, msg)
`define BCE_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

### hw/rtl/bce_pkg.sv
package bce_pkg;

   // Converter and field widths
   localparam int unsigned ADC_FULL_SCALE = 4095;
   localparam int unsigned CODE_W = 12;
   localparam int unsigned VREF_W = 11;
   localparam int unsigned MV_W = 14;
   localparam int unsigned PCT_W = 7;

   // Register port
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [0:0] CSR_IDX_REF_MV = 1'b0;
   localparam logic [VREF_W-1:0] VREF_RESET = 11'd1100;

   // mv = floor(code * vref * 6600 / (ADC_FULL_SCALE * 1000))
   // The fraction is reduced first: gcd(6600, 1000*fs) = 200 * gcd(33, fs).
   localparam int unsigned PROD_W = CODE_W + VREF_W;
   localparam int unsigned MV_GCD = 200 * ((ADC_FULL_SCALE % 3 == 0) ? 3 : 1)
                                        * ((ADC_FULL_SCALE % 11 == 0) ? 11 : 1);
   localparam int unsigned MV_NUM = 6600 / MV_GCD;
   localparam int unsigned MV_DEN = (ADC_FULL_SCALE * 1000) / MV_GCD;
   localparam int unsigned MV_DEN_W = $clog2(MV_DEN + 1);
   // Rounded-up reciprocal: exact for every product below 2**PROD_W
   localparam int unsigned MV_SHIFT = PROD_W + MV_DEN_W;
   localparam longint unsigned MV_MULT =
      ((64'd1 << MV_SHIFT) * MV_NUM + MV_DEN - 1) / MV_DEN;
   localparam int unsigned MV_MULT_W = $clog2(MV_MULT + 1);
   localparam int unsigned MV_PROD_W = PROD_W + MV_MULT_W;
   localparam int unsigned MV_FULL_W = MV_PROD_W - MV_SHIFT;
   localparam int unsigned MV_CMP_W = (MV_FULL_W > MV_W) ? MV_FULL_W : MV_W;

   // Voltage thresholds
   localparam int unsigned LEVEL_W = 13;
   localparam logic [MV_W-1:0] MV_FIELD_MAX = 14'd16383;
   localparam logic [LEVEL_W-1:0] MV_FULL_LEVEL = 13'd4200;
   localparam logic [LEVEL_W-1:0] MV_EMPTY_LEVEL = 13'd3000;
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
   localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

   // Discharge curve, highest point first
   localparam int unsigned CURVE_POINTS = 12;
   localparam int unsigned SEG_W = $clog2(CURVE_POINTS);
   localparam logic [LEVEL_W-1:0] CURVE_MV [CURVE_POINTS] = '{
      13'd4200, 13'd4120, 13'd4100, 13'd4050, 13'd3950, 13'd3820,
      13'd3750, 13'd3680, 13'd3600, 13'd3480, 13'd3300, 13'd3000
   };
   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
      7'd100, 7'd97, 7'd95, 7'd90, 7'd80, 7'd60,
      7'd40, 7'd20, 7'd10, 7'd5, 7'd2, 7'd0
   };

   // Per-segment data, indexed by the lower point of the segment.
   // Rise is pct[i-1] - pct[i]; widest segment span is 300 mV.
   localparam int unsigned OFF_W = 9;
   localparam int unsigned RISE_W = 5;
   localparam int unsigned NUM_W = RISE_W + OFF_W;
   localparam logic [RISE_W-1:0] SEG_RISE [CURVE_POINTS] = '{
      5'd0, 5'd3, 5'd2, 5'd5, 5'd10, 5'd20,
      5'd20, 5'd20, 5'd10, 5'd5, 5'd3, 5'd2
   };
   // ceil(2**22 / span): exact floor division for every numerator used
   localparam int unsigned RECIP_SHIFT = 22;
   localparam int unsigned RECIP_W = 18;
   localparam int unsigned QUOT_PROD_W = NUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] SEG_RECIP [CURVE_POINTS] = '{
      18'd0, 18'd52429, 18'd209716, 18'd83887, 18'd41944, 18'd32264,
      18'd59919, 18'd59919, 18'd52429, 18'd34953, 18'd23302, 18'd13982
   };

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [MV_W-1:0]  mv;
      logic             full;
      logic             empty;
      logic [SEG_W-1:0] seg;
      logic [OFF_W-1:0] off;
   } seg_entry_type;

   typedef struct packed {
      logic          push;
      seg_entry_type entry;
   } queue_push_type;

   typedef struct packed {
      logic [QCNT_W-1:0] level;
      logic              nonempty;
   } queue_status_type;

endpackage

### hw/rtl/battery_charge_estimator_top.sv
// Battery charge estimator: each request carries one 12-bit converter code of
// the battery voltage divided by 6.6 and yields one response with the battery
// voltage in mV (saturated at 16383) and the state of charge in percent from a
// 12-point discharge curve. One request is taken per cycle while req_stall is
// low; each response passes through two multiplier stages in the front end,
// the queue write and two stages (segment multiply, reciprocal divide) in the
// back end. A four-entry queue parts the two ends; a stalled response side
// holds off requests once the queue and the two front multiplier stages together
// hold four requests, with two more held in the back-end stages.
// The reference voltage register (reset 1100 mV) sits at byte address 0 of the
// register port and should be written only while no requests are in flight.
module battery_charge_estimator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bce_pkg::CODE_W-1:0]      req_adc_code,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bce_pkg::MV_W-1:0]        rsp_battery_millivolts,
   output logic [bce_pkg::PCT_W-1:0]       rsp_charge_percent,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bce_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bce_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bce_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import bce_pkg::*;

   logic [VREF_W-1:0]  ref_mv_ff, ref_mv_in;
   logic               csr_hit;
   queue_push_type     q_push;
   queue_status_type   q_status;
   seg_entry_type      q_head;
   logic               q_pop;

   // Reference voltage register
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_REF_MV);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(ref_mv_ff) : '0;

   always_comb begin
      ref_mv_in = ref_mv_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         ref_mv_in = csr_pwdata[VREF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_mv_ff <= VREF_RESET;
      end else begin
         ref_mv_ff <= ref_mv_in;
      end
   end

   bce_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_adc_code (req_adc_code),
      .ref_mv       (ref_mv_ff),
      .q_status     (q_status),
      .q_push       (q_push)
   );

   bce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_head   (q_head),
      .q_status (q_status)
   );

   bce_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_status               (q_status),
      .q_head                 (q_head),
      .q_pop                  (q_pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_battery_millivolts (rsp_battery_millivolts),
      .rsp_charge_percent     (rsp_charge_percent)
   );

endmodule

### hw/rtl/bce_front.sv
module bce_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bce_pkg::CODE_W-1:0]     req_adc_code,
   input  logic [bce_pkg::VREF_W-1:0]     ref_mv,
   input  bce_pkg::queue_status_type      q_status,
   output bce_pkg::queue_push_type        q_push
);
   import bce_pkg::*;

   logic                 accept;
   logic [QCNT_W-1:0]    committed;
   logic                 v1_ff, v1_in, v2_ff, v2_in;
   logic [PROD_W-1:0]    p1_ff, p1_in;
   logic [MV_PROD_W-1:0] p2_ff, p2_in;
   logic [MV_CMP_W-1:0]  mv_wide;
   logic [SEG_W-1:0]     seg;
   logic [LEVEL_W-1:0]   off_full;
   seg_entry_type        entry;

   // Hold off while the queue could not absorb everything in flight
   assign committed = q_status.level + QCNT_W'(v1_ff) + QCNT_W'(v2_ff);
   assign req_stall = (committed >= QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // Stage 1: code times reference; stage 2: times reciprocal
   always_comb begin
      v1_in = accept;
      p1_in = PROD_W'(req_adc_code) * PROD_W'(ref_mv);
      v2_in = v1_ff;
      p2_in = MV_PROD_W'(p1_ff) * MV_PROD_W'(MV_MULT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff <= p1_in;
      p2_ff <= p2_in;
   end

   // Classify: saturate, end flags, curve segment and offset into it
   always_comb begin
      mv_wide = MV_CMP_W'(p2_ff >> MV_SHIFT);
      seg = SEG_W'(CURVE_POINTS - 1);
      for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
         if (mv_wide >= MV_CMP_W'(CURVE_MV[i])) begin
            seg = SEG_W'(i);
         end
      end
      off_full = LEVEL_W'(mv_wide) - CURVE_MV[seg];
      entry.mv = (mv_wide > MV_CMP_W'(MV_FIELD_MAX)) ? MV_FIELD_MAX : MV_W'(mv_wide);
      entry.full = (mv_wide >= MV_CMP_W'(MV_FULL_LEVEL));
      entry.empty = (mv_wide <= MV_CMP_W'(MV_EMPTY_LEVEL));
      entry.seg = seg;
      entry.off = off_full[OFF_W-1:0];
      q_push.push = v2_ff;
      q_push.entry = entry;
   end

endmodule

### hw/rtl/bce_queue.sv
`include "battery_charge_estimator_top_macros.svh"

module bce_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  bce_pkg::queue_push_type    q_push,
   input  logic                       q_pop,
   output bce_pkg::seg_entry_type     q_head,
   output bce_pkg::queue_status_type  q_status
);
   import bce_pkg::*;

   seg_entry_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   level_ff, level_in;

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(q_push.push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(q_pop);
      level_in  = level_ff + QCNT_W'(q_push.push) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (q_push.push) begin
         entry_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

   assign q_head            = entry_ff[rd_ptr_ff];
   assign q_status.level    = level_ff;
   assign q_status.nonempty = (level_ff != '0);

   `BCE_ASSERT_SAME(a_no_push_full, clock, reset, level_ff == QCNT_W'(QUEUE_DEPTH), !q_push.push, "request pushed into full queue")
   `BCE_ASSERT_SAME(a_no_pop_empty, clock, reset, level_ff == '0, !q_pop, "pop from empty queue")
   `BCE_ASSERT_NEXT(a_level_up, clock, reset, q_push.push && !q_pop, level_ff == $past(level_ff) + QCNT_W'(1), "queue level did not rise")
   `BCE_ASSERT_NEXT(a_level_down, clock, reset, q_pop && !q_push.push, level_ff == $past(level_ff) - QCNT_W'(1), "queue level did not fall")

endmodule

### hw/rtl/bce_back.sv
module bce_back (
   input  logic                        clock,
   input  logic                        reset,
   input  bce_pkg::queue_status_type   q_status,
   input  bce_pkg::seg_entry_type      q_head,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bce_pkg::MV_W-1:0]    rsp_battery_millivolts,
   output logic [bce_pkg::PCT_W-1:0]   rsp_charge_percent
);
   import bce_pkg::*;

   logic                   advance;
   logic                   b1_valid_ff, b1_valid_in;
   seg_entry_type          b1_entry_ff;
   logic [NUM_W-1:0]       b1_num_ff, b1_num_in;
   logic                   out_valid_ff, out_valid_in;
   logic [MV_W-1:0]        out_mv_ff;
   logic [PCT_W-1:0]       out_pct_ff, out_pct_in;
   logic [QUOT_PROD_W-1:0] quot_prod;
   logic [PCT_W-1:0]       quot;
   logic [PCT_W-1:0]       interp;

   // Whole back end moves when the output slot is free or being taken
   assign advance = !out_valid_ff || !rsp_stall;
   assign q_pop   = advance && q_status.nonempty;

   // Stage 1: rise times offset
   always_comb begin
      b1_valid_in = q_pop;
      b1_num_in   = NUM_W'(SEG_RISE[q_head.seg]) * NUM_W'(q_head.off);
   end

   // Stage 2: divide by span via reciprocal, add lower point, clamp
   always_comb begin
      quot_prod = QUOT_PROD_W'(b1_num_ff) * QUOT_PROD_W'(SEG_RECIP[b1_entry_ff.seg]);
      quot      = PCT_W'(quot_prod >> RECIP_SHIFT);
      interp    = CURVE_PCT[b1_entry_ff.seg] + quot;
      if (b1_entry_ff.full) begin
         out_pct_in = PCT_FULL;
      end else if (b1_entry_ff.empty) begin
         out_pct_in = PCT_EMPTY;
      end else if (interp > PCT_FULL) begin
         out_pct_in = PCT_FULL;
      end else begin
         out_pct_in = interp;
      end
      out_valid_in = b1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= b1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_entry_ff <= q_head;
         b1_num_ff   <= b1_num_in;
         out_mv_ff   <= b1_entry_ff.mv;
         out_pct_ff  <= out_pct_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_battery_millivolts = out_mv_ff;
   assign rsp_charge_percent     = out_pct_ff;

endmodule
